@@ rtl/spl_pkg.sv @@
package spl_pkg;

  localparam int unsigned TableEntries   = 64;
  localparam int unsigned AddrBits       = 32;
  localparam int unsigned PortRangeStart = 1024;
  localparam int unsigned PortRangeEnd   = 5000;

  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_REKEY  = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_ALLOC  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_IN_USE    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  localparam logic [6:0] CountMax = 7'd127;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] local_addr;
    logic [31:0] remote_addr;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic        remote_wild;
    logic [7:0]  conn_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_handle;
    logic [15:0] alloc_port;
  } rsp_t;

  // Search key broadcast down the cell chain
  typedef struct packed {
    logic [31:0] la;
    logic [31:0] ra;
    logic [15:0] lp;
    logic [15:0] rp;
    logic        wild;
  } key_t;

  // Command carried from cell to cell
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_PROBE  = 3'd1,  // key compare, report first hit
    CMD_HANDLE = 3'd2,  // handle compare, report first hit
    CMD_WRITE  = 3'd3,  // write key into the tagged slot
    CMD_KILL   = 3'd4,  // invalidate key matches except the tagged slot
    CMD_FREE   = 3'd5   // clear the tagged slot
  } cmd_e;

endpackage

@@ rtl/spl_cell.sv @@
module spl_cell #(
  parameter int unsigned IdxBits = 6,
  parameter int unsigned Index   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spl_pkg::cmd_e        cmd_i,
  input  spl_pkg::key_t        key_i,
  input  logic [7:0]           handle_i,
  input  logic [IdxBits-1:0]   tag_i,
  input  logic                 hit_i,
  input  logic [IdxBits-1:0]   hit_idx_i,
  input  logic                 free_i,
  input  logic [IdxBits-1:0]   free_idx_i,
  output spl_pkg::cmd_e        cmd_o,
  output spl_pkg::key_t        key_o,
  output logic [7:0]           handle_o,
  output logic [IdxBits-1:0]   tag_o,
  output logic                 hit_o,
  output logic [IdxBits-1:0]   hit_idx_o,
  output logic                 free_o,
  output logic [IdxBits-1:0]   free_idx_o,
  output logic [7:0]           ent_handle_o,
  output logic [15:0]          ent_lp_o
);
  import spl_pkg::*;

  localparam logic [IdxBits-1:0] MyIdx = IdxBits'(Index);

  logic        valid_q;
  key_t        ent_q;
  logic [7:0]  hdl_q;
  logic        key_eq, hdl_eq, mine;

  assign key_eq = valid_q && (ent_q == key_i);
  assign hdl_eq = valid_q && (hdl_q == handle_i);
  assign mine   = (tag_i == MyIdx);

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_WRITE: if (mine) valid_q <= 1'b1;
        CMD_KILL:  if (!mine && key_eq) valid_q <= 1'b0;
        CMD_FREE:  if (mine) valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_WRITE && mine) begin
      ent_q <= key_i;
      if (hit_i) hdl_q <= handle_i;  // hit_i flags a fresh add
    end
  end

  // pass-through stage to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_o <= CMD_NONE;
      hit_o <= 1'b0;
      free_o <= 1'b0;
    end else begin
      cmd_o <= cmd_i;
      hit_o <= hit_i;
      free_o <= free_i;
      if (cmd_i == CMD_PROBE && !hit_i && key_eq) hit_o <= 1'b1;
      if (cmd_i == CMD_HANDLE && !hit_i && hdl_eq) hit_o <= 1'b1;
      if ((cmd_i == CMD_PROBE || cmd_i == CMD_HANDLE) && !free_i && !valid_q)
        free_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    key_o    <= key_i;
    handle_o <= handle_i;
    tag_o    <= tag_i;
    hit_idx_o  <= hit_idx_i;
    free_idx_o <= free_idx_i;
    if (cmd_i == CMD_PROBE && !hit_i && key_eq) hit_idx_o <= MyIdx;
    if (cmd_i == CMD_HANDLE && !hit_i && hdl_eq) hit_idx_o <= MyIdx;
    if ((cmd_i == CMD_PROBE || cmd_i == CMD_HANDLE) && !free_i && !valid_q)
      free_idx_o <= MyIdx;
  end

  assign ent_handle_o = hdl_q;
  assign ent_lp_o     = ent_q.lp;

endmodule

@@ rtl/spl_ports.sv @@
module spl_ports #(
  parameter int unsigned PortRangeStart = spl_pkg::PortRangeStart,
  parameter int unsigned PortRangeEnd   = spl_pkg::PortRangeEnd
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,     // clearing pass write of zero
  input  logic        inc_i,
  input  logic        dec_i,
  input  logic        rd_i,
  input  logic [15:0] port_i,
  output logic        in_range_o,
  output logic [6:0]  count_o   // registered, valid in the cycle after rd_i
);
  import spl_pkg::*;

  localparam int unsigned Span  = PortRangeEnd - PortRangeStart;
  localparam int unsigned IBits = (Span > 1) ? $clog2(Span) : 1;

  logic [6:0]       mem_q [Span];
  logic [IBits-1:0] idx;
  logic [16:0]      off;

  assign off        = {1'b0, port_i} - 17'(PortRangeStart);
  assign in_range_o = (32'(port_i) >= PortRangeStart) && (32'(port_i) < PortRangeEnd);
  assign idx        = off[IBits-1:0];

  // single-port count memory; read-modify-write is sequenced by the top
  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      mem_q[idx] <= 7'd0;
    end else if (inc_i && in_range_o && count_o != CountMax) begin
      mem_q[idx] <= count_o + 7'd1;
    end else if (dec_i && in_range_o && count_o != 7'd0) begin
      mem_q[idx] <= count_o - 7'd1;
    end
    if (rd_i) count_o <= in_range_o ? mem_q[idx] : 7'd0;
  end

  logic unused;
  assign unused = rst_ni;

endmodule

@@ rtl/socket_pair_lookup_table_unit.sv @@
// Socket pair demultiplexing table with ephemeral port allocator. Entries live
// in a chain of TABLE_ENTRIES cells; each command (key probe, handle search,
// write, invalidate, free) walks the chain one cell per clock. Lookup takes up
// to four passes. Add and remove take one pass plus a write and a port count
// update (read, then write). Rekey takes two passes (handle search,
// invalidate) plus a write. Allocate reads one port count at a time (read,
// then check) and may scan the whole range. Each request also passes through
// an accept step and waits in the output register until it is taken. After
// reset a clearing pass over the port range zeroes the port counts; no request
// is taken then.
// One request is in flight at a time; the result is held in an output register.
module socket_pair_lookup_table_unit #(
  parameter int unsigned TABLE_ENTRIES    = spl_pkg::TableEntries,
  parameter int unsigned PORT_RANGE_START = spl_pkg::PortRangeStart,
  parameter int unsigned PORT_RANGE_END   = spl_pkg::PortRangeEnd
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spl_pkg::rsp_t out_data_o
);
  import spl_pkg::*;

  localparam int unsigned N     = TABLE_ENTRIES;
  localparam int unsigned IB    = $clog2(N);
  localparam int unsigned CB    = $clog2(N + 2);
  localparam int unsigned Span  = PORT_RANGE_END - PORT_RANGE_START;
  localparam logic [15:0] PStart = 16'(PORT_RANGE_START);
  localparam logic [15:0] PEnd   = 16'(PORT_RANGE_END);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_ISSUE  = 11'b00000000100,
    S_WAIT   = 11'b00000001000,
    S_CNT_RD = 11'b00000010000,
    S_CNT_WR = 11'b00000100000,
    S_AL_RD  = 11'b00001000000,
    S_AL_CHK = 11'b00010000000,
    S_DONE   = 11'b00100000000,
    S_KILL   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e      state_q;
  req_t        req_q;
  rsp_t        rsp_q;
  logic [1:0]  phase_q;      // probe number or sub-step
  logic [CB-1:0] cnt_q;
  logic [IB-1:0] slot_q;     // target entry
  logic [15:0] port_q;       // port for count update / alloc cursor walk
  logic        inc_q;
  logic [15:0] last_q;
  logic [15:0] clr_q;

  // chain wiring
  cmd_e        c_cmd  [N+1];
  key_t        c_key  [N+1];
  logic [7:0]  c_hdl  [N+1];
  logic [IB-1:0] c_tag [N+1];
  logic        c_hit  [N+1];
  logic [IB-1:0] c_hidx [N+1];
  logic        c_free [N+1];
  logic [IB-1:0] c_fidx [N+1];
  logic [7:0]  e_hdl  [N];
  logic [15:0] e_lp   [N];

  cmd_e  inj_cmd;
  key_t  inj_key;
  logic  inj_add;

  assign c_cmd[0]  = inj_cmd;
  assign c_key[0]  = inj_key;
  assign c_hdl[0]  = req_q.conn_handle;
  assign c_tag[0]  = slot_q;
  assign c_hit[0]  = inj_add;
  assign c_hidx[0] = '0;
  assign c_free[0] = 1'b0;
  assign c_fidx[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    spl_cell #(.IdxBits(IB), .Index(g)) u_cell (
      .clk_i, .rst_ni,
      .cmd_i(c_cmd[g]), .key_i(c_key[g]), .handle_i(c_hdl[g]), .tag_i(c_tag[g]),
      .hit_i(c_hit[g]), .hit_idx_i(c_hidx[g]), .free_i(c_free[g]),
      .free_idx_i(c_fidx[g]),
      .cmd_o(c_cmd[g+1]), .key_o(c_key[g+1]), .handle_o(c_hdl[g+1]),
      .tag_o(c_tag[g+1]), .hit_o(c_hit[g+1]), .hit_idx_o(c_hidx[g+1]),
      .free_o(c_free[g+1]), .free_idx_o(c_fidx[g+1]),
      .ent_handle_o(e_hdl[g]), .ent_lp_o(e_lp[g])
    );
  end

  // port counts
  logic        p_clr, p_inc, p_dec, p_rd, p_inr;
  logic [15:0] p_port;
  logic [6:0]  p_cnt;

  spl_ports #(.PortRangeStart(PORT_RANGE_START), .PortRangeEnd(PORT_RANGE_END)) u_ports (
    .clk_i, .rst_ni, .clr_i(p_clr), .inc_i(p_inc), .dec_i(p_dec), .rd_i(p_rd),
    .port_i(p_port), .in_range_o(p_inr), .count_o(p_cnt)
  );

  function automatic logic [15:0] nxt(input logic [15:0] p);
    logic [15:0] q;
    q = p + 16'd1;
    return (q == PEnd) ? PStart : q;
  endfunction

  // key for the current probe
  always_comb begin
    inj_key = '0;
    inj_key.lp = req_q.local_port;
    unique case (req_q.kind)
      KIND_LOOKUP: begin
        inj_key.la   = phase_q[0] ? 32'd0 : req_q.local_addr;
        inj_key.ra   = phase_q[1] ? 32'd0 : req_q.remote_addr;
        inj_key.rp   = phase_q[1] ? 16'd0 : req_q.remote_port;
        inj_key.wild = phase_q[1];
        if (phase_q == 2'd1) inj_key.la = 32'd0;
        if (phase_q == 2'd2) inj_key.la = req_q.local_addr;
      end
      default: begin
        inj_key.la   = req_q.local_addr;
        inj_key.ra   = req_q.remote_addr;
        inj_key.rp   = req_q.remote_wild ? 16'd0 : req_q.remote_port;
        inj_key.wild = req_q.remote_wild;
        if (req_q.kind == KIND_REKEY) inj_key.lp = port_q;
      end
    endcase
  end

  always_comb begin
    inj_cmd = CMD_NONE;
    inj_add = 1'b0;
    if (state_q == S_ISSUE) begin
      unique case (req_q.kind) inside
        KIND_REKEY, KIND_REMOVE: inj_cmd = (phase_q == 2'd0) ? CMD_HANDLE : CMD_KILL;
        default: inj_cmd = CMD_PROBE;
      endcase
    end else if (state_q == S_DONE) begin
      inj_cmd = (req_q.kind == KIND_REMOVE) ? CMD_FREE : CMD_WRITE;
      inj_add = (req_q.kind == KIND_ADD);
    end else if (state_q == S_KILL) begin
      inj_cmd = CMD_KILL;
    end
  end

  always_comb begin
    p_clr  = (state_q == S_CLEAR);
    p_port = (state_q == S_CLEAR) ? clr_q : port_q;
    p_rd   = (state_q == S_CNT_RD) || (state_q == S_AL_RD);
    p_inc  = (state_q == S_CNT_WR) && inc_q;
    p_dec  = (state_q == S_CNT_WR) && !inc_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  // command injected in S_ISSUE leaves the last cell when cnt_q reaches N-1
  logic chain_done;
  assign chain_done = (cnt_q == CB'(N - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= '0;
      cnt_q   <= '0;
      last_q  <= PStart;
      clr_q   <= PStart;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 16'd1;
          if (clr_q == PEnd - 16'd1 || Span == 0) state_q <= S_IDLE;
        end
        S_IDLE: if (in_valid_i) begin
          phase_q <= '0;
          rsp_q   <= '{status: ST_NOT_FOUND, found_handle: 8'd0, alloc_port: 16'd0};
          port_q  <= nxt(last_q);
          unique case (in_data_i.kind) inside
            KIND_LOOKUP, KIND_ADD, KIND_REKEY, KIND_REMOVE: state_q <= S_ISSUE;
            KIND_ALLOC: state_q <= S_AL_RD;
            default: state_q <= S_OUT;
          endcase
        end
        S_ISSUE: begin
          cnt_q   <= '0;
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          cnt_q <= cnt_q + CB'(1);
          if (chain_done) begin
            unique case (req_q.kind)
              KIND_LOOKUP: begin
                if (c_hit[N]) begin
                  rsp_q.status <= ST_OK;
                  rsp_q.found_handle <= e_hdl[c_hidx[N]];
                  state_q <= S_OUT;
                end else if (phase_q == 2'd3) begin
                  state_q <= S_OUT;
                end else begin
                  phase_q <= phase_q + 2'd1;
                  state_q <= S_ISSUE;
                end
              end
              KIND_ADD: begin
                if (c_hit[N]) begin
                  rsp_q.status <= ST_IN_USE;
                  state_q <= S_OUT;
                end else if (!c_free[N]) begin
                  rsp_q.status <= ST_FULL;
                  state_q <= S_OUT;
                end else begin
                  slot_q <= c_fidx[N];
                  port_q <= req_q.local_port;
                  inc_q  <= 1'b1;
                  rsp_q.status <= ST_OK;
                  state_q <= S_DONE;
                end
              end
              default: begin  // rekey and remove
                if (phase_q == 2'd0) begin
                  if (!c_hit[N]) begin
                    state_q <= S_OUT;
                  end else begin
                    slot_q <= c_hidx[N];
                    port_q <= e_lp[c_hidx[N]];
                    inc_q  <= 1'b0;
                    rsp_q.status <= ST_OK;
                    state_q <= (req_q.kind == KIND_REMOVE) ? S_DONE : S_KILL;
                  end
                end else begin
                  state_q <= S_DONE;
                end
              end
            endcase
          end
        end
        S_KILL: begin
          phase_q <= 2'd1;
          cnt_q   <= '0;
          state_q <= S_WAIT;
        end
        S_DONE: begin
          // writes land in the cell chain behind later idle traffic
          cnt_q   <= '0;
          state_q <= (req_q.kind == KIND_REKEY) ? S_OUT : S_CNT_RD;
        end
        S_CNT_RD: state_q <= S_CNT_WR;
        S_CNT_WR: state_q <= S_OUT;
        S_AL_RD: state_q <= S_AL_CHK;
        S_AL_CHK: begin
          if (!p_inr || p_cnt == 7'd0) begin
            last_q <= port_q;
            rsp_q.status <= ST_OK;
            rsp_q.alloc_port <= port_q;
            state_q <= S_OUT;
          end else if (port_q == last_q) begin
            rsp_q.status <= ST_EXHAUSTED;
            state_q <= S_OUT;
          end else begin
            port_q  <= nxt(port_q);
            state_q <= S_AL_RD;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) req_q <= in_data_i;
  end

endmodule
